### rtl/bod_pkg.sv
// Package with the shared constants, codes and controller interface types of the deque.
package bod_pkg;

  localparam int DEPTH     = 16;
  localparam int DATA_W    = 32;
  localparam int ACT_W     = 3;
  localparam int OFF_W     = 16;
  localparam int CAP_W     = 5;
  localparam int ECOUNT_W  = 5;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int MOD_BITS  = 4;
  localparam int MOD_STEPS = OFF_W / MOD_BITS;
  localparam int STEP_W    = $clog2(MOD_STEPS);
  localparam int LIM_CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int CAP_RESET = 16;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_WRITE      = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_UPDATE,
    ST_READ,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic accept;
    logic mod_step;
    logic update;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic need_mod;
    logic mod_last;
  } status_t;

endpackage

### rtl/bounded_overwrite_deque.sv
// Top level of the bounded overwrite deque: one operation in flight at a time.
// Each item passes the update, read and done states; a non-empty indexed write first runs the mod
// state, in which the remainder unit reduces the 16-bit offset modulo the count 4 bits per cycle.
// The store is a circular buffer with head pointer and count and at most one write per item.
// Reset clears the count, head pointer and capacity (to 16); store contents are not cleared.
module bounded_overwrite_deque import bod_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ACT_W-1:0]    action_i,
  input  logic [DATA_W-1:0]   data_value_i,
  input  logic [OFF_W-1:0]    position_offset_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [ECOUNT_W-1:0] element_count_o,
  output logic [DATA_W-1:0]   front_value_o,
  output logic [DATA_W-1:0]   back_value_o,
  output logic                error_flag_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CAP_W-1:0]    capacity_limit_i
);

  cmd_t    cmd;
  status_t sts;

  assign cfg_ready_o = 1'b1;

  bod_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  bod_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .action_i          (action_i),
    .data_value_i      (data_value_i),
    .position_offset_i (position_offset_i),
    .cfg_valid_i       (cfg_valid_i),
    .capacity_limit_i  (capacity_limit_i),
    .element_count_o   (element_count_o),
    .front_value_o     (front_value_o),
    .back_value_o      (back_value_o),
    .error_flag_o      (error_flag_o)
  );

endmodule

### rtl/bod_ctrl.sv
// Controller state machine that sequences one deque operation at a time.
module bod_ctrl import bod_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  logic    out_ready_i,
  output logic    out_valid_o,
  output cmd_t    cmd_o,
  input  status_t sts_i
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.need_mod ? ST_MOD : ST_UPDATE;
        end
      end
      ST_MOD: begin
        if (sts_i.mod_last) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: state_d = ST_READ;
      ST_READ:   state_d = ST_DONE;
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    in_ready_o     = 1'b0;
    out_valid_d    = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_MOD:    cmd_o.mod_step = 1'b1;
      ST_UPDATE: cmd_o.update   = 1'b1;
      ST_READ:   ;
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### rtl/bod_dp.sv
// Datapath with the circular element store, pointers, offset remainder unit and result registers.
module bod_dp import bod_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output status_t             sts_o,
  input  logic [ACT_W-1:0]    action_i,
  input  logic [DATA_W-1:0]   data_value_i,
  input  logic [OFF_W-1:0]    position_offset_i,
  input  logic                cfg_valid_i,
  input  logic [CAP_W-1:0]    capacity_limit_i,
  output logic [ECOUNT_W-1:0] element_count_o,
  output logic [DATA_W-1:0]   front_value_o,
  output logic [DATA_W-1:0]   back_value_o,
  output logic                error_flag_o
);

  function automatic logic [CNT_W-1:0] eff_limit(input logic [CAP_W-1:0] cap);
    logic [LIM_CMP_W-1:0] c;
    c = LIM_CMP_W'(cap);
    if (c == '0) begin
      return CNT_W'(1);
    end else if (c > LIM_CMP_W'(DEPTH)) begin
      return CNT_W'(DEPTH);
    end
    return CNT_W'(c);
  endfunction

  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(a) + (CNT_W + 1)'(b);
    if (s >= (CNT_W + 1)'(DEPTH)) begin
      s = s - (CNT_W + 1)'(DEPTH);
    end
    return PTR_W'(s);
  endfunction

  logic [DATA_W-1:0]   mem [DEPTH];
  logic [CAP_W-1:0]    cap_q;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [PTR_W-1:0]    head_q, head_d;
  logic [ACT_W-1:0]    act_q;
  logic [DATA_W-1:0]   val_q;
  logic [OFF_W-1:0]    off_q;
  logic [CNT_W-1:0]    rem_q, rem_d;
  logic [STEP_W-1:0]   step_q;
  logic                err_q, err_d;
  logic                wr_en;
  logic [PTR_W-1:0]    wr_addr;
  logic [DATA_W-1:0]   rd_front_q, rd_back_q;
  logic [CNT_W-1:0]    lim;
  logic [CNT_W-1:0]    new_lim;

  assign lim     = eff_limit(cap_q);
  assign new_lim = eff_limit(capacity_limit_i);

  assign sts_o.need_mod = (action_e'(action_i) == ACT_WRITE) && (cnt_q != '0);
  assign sts_o.mod_last = (step_q == STEP_W'(MOD_STEPS - 1));

  always_comb begin
    logic [CNT_W:0] t;
    rem_d = rem_q;
    for (int i = 0; i < MOD_BITS; i++) begin
      t = {rem_d, off_q[OFF_W-1-i]};
      if (t >= (CNT_W + 1)'(cnt_q)) begin
        t = t - (CNT_W + 1)'(cnt_q);
      end
      rem_d = CNT_W'(t);
    end
  end

  always_comb begin
    cnt_d   = cnt_q;
    head_d  = head_q;
    err_d   = 1'b0;
    wr_en   = 1'b0;
    wr_addr = head_q;
    case (action_e'(act_q))
      ACT_PUSH_FRONT: begin
        head_d  = (head_q == '0) ? PTR_W'(DEPTH - 1) : head_q - PTR_W'(1);
        wr_en   = 1'b1;
        wr_addr = head_d;
        if (cnt_q < lim) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ACT_PUSH_BACK: begin
        wr_en   = 1'b1;
        wr_addr = wrap_add(head_q, cnt_q);
        if (cnt_q < lim) begin
          cnt_d = cnt_q + CNT_W'(1);
        end else begin
          head_d = wrap_add(head_q, CNT_W'(1));
        end
      end
      ACT_POP_FRONT: begin
        if (cnt_q == '0) begin
          err_d = 1'b1;
        end else begin
          head_d = wrap_add(head_q, CNT_W'(1));
          cnt_d  = cnt_q - CNT_W'(1);
        end
      end
      ACT_POP_BACK: begin
        if (cnt_q == '0) begin
          err_d = 1'b1;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      ACT_WRITE: begin
        if (cnt_q == '0) begin
          err_d = 1'b1;
        end else begin
          wr_en   = 1'b1;
          wr_addr = wrap_add(head_q, rem_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CAP_W'(CAP_RESET);
      cnt_q  <= '0;
      head_q <= '0;
      step_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        cap_q <= capacity_limit_i;
        if (cnt_q > new_lim) begin
          cnt_q <= new_lim;
        end
      end else if (cmd_i.update) begin
        cnt_q  <= cnt_d;
        head_q <= head_d;
      end
      if (cmd_i.accept) begin
        step_q <= '0;
      end else if (cmd_i.mod_step) begin
        step_q <= step_q + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      act_q <= action_i;
      val_q <= data_value_i;
      off_q <= position_offset_i;
      rem_q <= '0;
    end else if (cmd_i.mod_step) begin
      off_q <= off_q << MOD_BITS;
      rem_q <= rem_d;
    end
    if (cmd_i.update) begin
      err_q <= err_d;
    end
    if (cmd_i.update && wr_en) begin
      mem[wr_addr] <= val_q;
    end
    rd_front_q <= mem[head_q];
    rd_back_q  <= mem[wrap_add(head_q, cnt_q - CNT_W'(1))];
    if (cmd_i.load_out) begin
      element_count_o <= ECOUNT_W'(cnt_q);
      front_value_o   <= (cnt_q == '0) ? '0 : rd_front_q;
      back_value_o    <= (cnt_q == '0) ? '0 : rd_back_q;
      error_flag_o    <= err_q;
    end
  end

endmodule
